// ===== hdl/tlpw_pkg.sv =====
package tlpw_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROWCOL,
    ST_EMIT
  } tlpw_state_t;

  // Operation carried in the input tuser.
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } tlpw_op_t;

  // Pixel formats.
  localparam logic [1:0] FMT_32   = 2'd0;
  localparam logic [1:0] FMT_24   = 2'd1;
  localparam logic [1:0] FMT_565  = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  // Write size codes on the result.
  localparam logic [1:0] WB_FOUR  = 2'd0;
  localparam logic [1:0] WB_THREE = 2'd1;
  localparam logic [1:0] WB_TWO   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd4;

  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned SCREEN_W = 13;
  localparam int unsigned PITCH_W  = 16;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned PEN_W    = 4;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [PITCH_W-1:0]  ROW_PITCH_RST     = 16'd2560;

  // Result tdata: address, data, size code, padded to whole bytes.
  localparam int unsigned OUT_DW = 72;

endpackage

// ===== hdl/thick_line_pixel_writer_core.sv =====
// Thick-pen line rasterizer. A start transfer (tuser = 0) loads both endpoints, the pen
// size and the color in one cycle and produces nothing. A step transfer (tuser = 1) on an
// active line emits the pen square around the current point, rows from low y to high y and
// columns from low x to high x, then makes one Bresenham step or, at the end, retires
// the line; a step on an idle line is swallowed. One shared datapath handles each pen
// pixel: a screen-mapping and clipping state, then an address state that waits for the
// sink, with a single row-by-pitch multiplier that loads the output register.
// The pen square spans -off..+off in x and y around the current point, where off is
// min(pen_size/2, MAX_PEN_OFFSET). The input is ready only while the sequencer is idle.
module thick_line_pixel_writer_core
  import tlpw_pkg::*;
#(
  parameter int MAX_PEN_OFFSET = 3,
  parameter int COORD_BITS     = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]     cfg_wdata,
  // Input: start_x, start_y, end_x, end_y, pen_size, draw_color (low bits first).
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((4*COORD_BITS+PEN_W+COLOR_W+7)/8)*8-1:0] in_tdata,
  // Input tuser: operation.
  input  logic [0:0]            in_tuser,
  // Output: write_address, write_data, write_bytes (low bits first).
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DW-1:0]     out_tdata,
  // Output tuser: write_valid, line_done (low bit first).
  output logic [1:0]            out_tuser,
  // Output tlast: last_of_point.
  output logic                  out_tlast
);

  localparam int CB = COORD_BITS;
  // Signed width for screen column and row before clipping.
  localparam int SW = ((CB > SCREEN_W) ? CB : SCREEN_W) + 2;
  localparam int PROD_W = SCREEN_W + PITCH_W;

  // Configuration registers.
  logic [31:0]          frame_base_r;
  logic [SCREEN_W-1:0]  screen_width_r;
  logic [SCREEN_W-1:0]  screen_height_r;
  logic [PITCH_W-1:0]   row_pitch_r;
  logic [1:0]           pixel_format_r;

  // Line state.
  logic [CB-1:0]        cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic [CB:0]          delta_x_r;
  logic [CB+1:0]        neg_delta_y_r;
  logic                 dir_x_r, dir_y_r;
  logic [CB+2:0]        err_r;
  logic [COLOR_W-1:0]   color_r;
  logic [1:0]           pen_off_r;
  logic                 active_r;

  // Pen pixel sequencing.
  tlpw_state_t          state_r, state_nxt;
  logic signed [2:0]    tx_r, ty_r;
  logic [SCREEN_W-1:0]  col_r, row_r;
  logic                 on_r;

  // Output register.
  logic                 out_valid_r;
  logic [31:0]          out_addr_r, out_data_r;
  logic [1:0]           out_bytes_r;
  logic                 out_wv_r, out_last_r, out_done_r;

  // Input fields.
  logic                 in_fire;
  logic [CB-1:0]        sx, sy, ex, ey;
  logic [PEN_W-1:0]     pen;
  logic [COLOR_W-1:0]   in_color;

  assign in_fire  = in_tvalid && in_tready;
  assign sx       = in_tdata[CB-1:0];
  assign sy       = in_tdata[2*CB-1:CB];
  assign ex       = in_tdata[3*CB-1:2*CB];
  assign ey       = in_tdata[4*CB-1:3*CB];
  assign pen      = in_tdata[4*CB+PEN_W-1:4*CB];
  assign in_color = in_tdata[4*CB+PEN_W+COLOR_W-1:4*CB+PEN_W];

  // Line setup.
  logic [CB:0]          ddx, ddy, adx, ady;
  logic [CB+1:0]        ndy_start;
  logic [CB+2:0]        err_start;
  logic [2:0]           pen_half;
  logic [1:0]           off_start;
  logic signed [2:0]    off_s;

  always_comb begin
    ddx       = {ex[CB-1], ex} - {sx[CB-1], sx};
    ddy       = {ey[CB-1], ey} - {sy[CB-1], sy};
    adx       = ddx[CB] ? (~ddx + 1'b1) : ddx;
    ady       = ddy[CB] ? (~ddy + 1'b1) : ddy;
    ndy_start = (CB+2)'(0) - {1'b0, ady};
    err_start = {2'b00, adx} + {ndy_start[CB+1], ndy_start};
    pen_half  = pen[PEN_W-1:1];
    off_start = (pen_half > 3'(MAX_PEN_OFFSET)) ? 2'(MAX_PEN_OFFSET) : pen_half[1:0];
    off_s     = $signed({1'b0, pen_off_r});
  end

  // Screen mapping and clipping of the current pen pixel.
  logic [SW-1:0]        col_s, row_s;
  logic                 on_s;

  always_comb begin
    col_s = {{(SW-SCREEN_W+1){1'b0}}, screen_width_r[SCREEN_W-1:1]}
          + {{(SW-CB){cur_x_r[CB-1]}}, cur_x_r}
          + {{(SW-3){tx_r[2]}}, tx_r};
    row_s = {{(SW-SCREEN_W+1){1'b0}}, screen_height_r[SCREEN_W-1:1]}
          - ({{(SW-CB){cur_y_r[CB-1]}}, cur_y_r} + {{(SW-3){ty_r[2]}}, ty_r});
    on_s  = (pixel_format_r != FMT_NONE) && !col_s[SW-1] && !row_s[SW-1]
         && (col_s < {{(SW-SCREEN_W){1'b0}}, screen_width_r})
         && (row_s < {{(SW-SCREEN_W){1'b0}}, screen_height_r});
  end

  // Address, data and size code of the registered pixel.
  logic [PROD_W-1:0]    row_prod;
  logic [SCREEN_W+1:0]  col_bytes;
  logic [31:0]          pix_addr, pix_data;
  logic [1:0]           size_code;

  always_comb begin
    row_prod = row_r * row_pitch_r;
    case (pixel_format_r)
      FMT_32:  col_bytes = {col_r, 2'b00};
      FMT_24:  col_bytes = {1'b0, col_r, 1'b0} + {2'b00, col_r};
      default: col_bytes = {1'b0, col_r, 1'b0};
    endcase
    case (pixel_format_r)
      FMT_565: pix_data = {16'h0000, color_r[23:19], color_r[15:10], color_r[7:3]};
      default: pix_data = {8'h00, color_r};
    endcase
    case (pixel_format_r)
      FMT_24:  size_code = WB_THREE;
      FMT_565: size_code = WB_TWO;
      default: size_code = WB_FOUR;
    endcase
    pix_addr = frame_base_r + 32'(row_prod) + 32'(col_bytes);
  end

  // Bresenham step.
  logic signed [CB+3:0] e2, ndy_ext, dx_ext;
  logic [CB+2:0]        err_step;
  logic                 step_x, step_y, at_end;

  always_comb begin
    e2       = $signed({err_r, 1'b0});
    ndy_ext  = $signed({{2{neg_delta_y_r[CB+1]}}, neg_delta_y_r});
    dx_ext   = $signed({3'b000, delta_x_r});
    step_x   = (e2 >= ndy_ext);
    step_y   = (e2 <= dx_ext);
    err_step = err_r + (step_x ? {neg_delta_y_r[CB+1], neg_delta_y_r} : (CB+3)'(0))
                     + (step_y ? {2'b00, delta_x_r} : (CB+3)'(0));
    at_end   = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
  end

  // Sequencer.
  logic emit_go, pix_last, tx_wrap;

  assign tx_wrap  = (tx_r == off_s);
  assign pix_last = tx_wrap && (ty_r == off_s);

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    emit_go   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && (in_tuser[0] == OP_STEP) && active_r) begin
          state_nxt = ST_ROWCOL;
        end
      end
      ST_ROWCOL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        emit_go = !out_valid_r || out_tready;
        if (emit_go) begin
          state_nxt = pix_last ? ST_IDLE : ST_ROWCOL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r    <= '0;
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      row_pitch_r     <= ROW_PITCH_RST;
      pixel_format_r  <= FMT_32;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_BASE:    frame_base_r    <= cfg_wdata;
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[SCREEN_W-1:0];
        REG_ROW_PITCH:     row_pitch_r     <= cfg_wdata[PITCH_W-1:0];
        REG_PIXEL_FORMAT:  pixel_format_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Line state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      tgt_x_r       <= '0;
      tgt_y_r       <= '0;
      delta_x_r     <= '0;
      neg_delta_y_r <= '0;
      dir_x_r       <= 1'b0;
      dir_y_r       <= 1'b0;
      err_r         <= '0;
      color_r       <= '0;
      pen_off_r     <= '0;
      active_r      <= 1'b0;
    end else if (in_fire && (in_tuser[0] == OP_START)) begin
      cur_x_r       <= sx;
      cur_y_r       <= sy;
      tgt_x_r       <= ex;
      tgt_y_r       <= ey;
      delta_x_r     <= adx;
      neg_delta_y_r <= ndy_start;
      dir_x_r       <= ($signed(sx) < $signed(ex));
      dir_y_r       <= ($signed(sy) < $signed(ey));
      err_r         <= err_start;
      color_r       <= in_color;
      pen_off_r     <= off_start;
      active_r      <= 1'b1;
    end else if (emit_go && pix_last) begin
      // The end point's square has gone out; otherwise move one point.
      if (at_end) begin
        active_r <= 1'b0;
      end else begin
        err_r <= err_step;
        if (step_x) begin
          cur_x_r <= dir_x_r ? cur_x_r + 1'b1 : cur_x_r - 1'b1;
        end
        if (step_y) begin
          cur_y_r <= dir_y_r ? cur_y_r + 1'b1 : cur_y_r - 1'b1;
        end
      end
    end
  end

  // Pen offsets and clipped pixel position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= '0;
      ty_r <= '0;
      on_r <= 1'b0;
    end else begin
      if (state_r == ST_IDLE) begin
        tx_r <= -off_s;
        ty_r <= -off_s;
      end else if (emit_go) begin
        if (tx_wrap) begin
          tx_r <= -off_s;
          ty_r <= ty_r + 3'sd1;
        end else begin
          tx_r <= tx_r + 3'sd1;
        end
      end
      if (state_r == ST_ROWCOL) begin
        on_r <= on_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ROWCOL) begin
      col_r <= col_s[SCREEN_W-1:0];
      row_r <= row_s[SCREEN_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_addr_r  <= on_r ? pix_addr : 32'h0;
      out_data_r  <= on_r ? pix_data : 32'h0;
      out_bytes_r <= size_code;
      out_wv_r    <= on_r;
      out_last_r  <= pix_last;
      out_done_r  <= at_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW-66)'(0), out_bytes_r, out_data_r, out_addr_r};
  assign out_tuser  = {out_done_r, out_wv_r};
  assign out_tlast  = out_last_r;

  // An invalid write carries neither address nor data.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wv_r) |-> (out_addr_r == 32'h0 && out_data_r == 32'h0))
    else $error("invalid write with nonzero address or data");

  // The last pixel of the end point's square retires the line.
  a_end_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && pix_last && at_end) |=> !active_r)
    else $error("line still active after its end point");

  // A step on an active line starts the pixel sequence at the pen corner.
  a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser[0] == OP_STEP) && active_r)
      |=> (state_r == ST_ROWCOL && tx_r == -off_s && ty_r == -off_s))
    else $error("step did not start the pen square");

  // Pen offsets stay inside the square while pixels are produced.
  a_pen_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROWCOL || state_r == ST_EMIT)
      |-> (tx_r >= -off_s && tx_r <= off_s && ty_r >= -off_s && ty_r <= off_s))
    else $error("pen offset out of range");

  // No valid write when the pixel format is unsupported.
  a_format_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_wv_r) |-> (pixel_format_r != FMT_NONE))
    else $error("valid write with unsupported format");

endmodule
